@@ hdl/bed_pkg.sv @@
// shared types and constants of the broadcast element-wise divider
// no dependencies; compiled first
package bed_pkg;

  localparam int ADDR_W = 40;
  localparam int DATA_W = 32;
  localparam int APB_DW = 64;
  localparam int APB_AW = 6;

  localparam logic [ADDR_W-1:0] EXT_RESET = 40'h01_0101_0101;
  localparam logic signed [DATA_W-1:0] QMAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] QMIN = 32'sh8000_0000;

  // status of the address walker toward the top level
  typedef struct packed {
    logic ready;
    logic done;
  } walk_stat_t;

  // status of the serial divider toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hdl/bed_if.sv @@
// stream interfaces for operand and result transfers
// depends on bed_pkg
interface bed_in_if;
  logic valid;
  logic ready;
  logic signed [bed_pkg::DATA_W-1:0] dividend;
  logic signed [bed_pkg::DATA_W-1:0] divisor;
  modport source (output valid, dividend, divisor, input ready);
  modport sink (input valid, dividend, divisor, output ready);
endinterface

interface bed_out_if;
  logic valid;
  logic ready;
  logic [bed_pkg::ADDR_W-1:0] out_address;
  logic signed [bed_pkg::DATA_W-1:0] quotient;
  logic zero_divisor;
  logic [bed_pkg::ADDR_W-1:0] next_a_address;
  logic [bed_pkg::ADDR_W-1:0] next_b_address;
  logic last;
  modport source (output valid, out_address, quotient, zero_divisor, next_a_address,
                  next_b_address, last, input ready);
  modport sink (input valid, out_address, quotient, zero_divisor, next_a_address,
                next_b_address, last, output ready);
endinterface

@@ hdl/bed_divider.sv @@
// bit-serial restoring divider, one quotient bit per cycle, with saturation and clamp
// depends on bed_pkg
module bed_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [bed_pkg::DATA_W-1:0] dividend,
  input  logic signed [bed_pkg::DATA_W-1:0] divisor,
  input  logic signed [bed_pkg::DATA_W-1:0] clamp_min,
  input  logic signed [bed_pkg::DATA_W-1:0] clamp_max,
  output bed_pkg::div_stat_t stat,
  output logic signed [bed_pkg::DATA_W-1:0] quotient,
  output logic zero_divisor
);
  import bed_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN, D_DONE} dstate_t;

  dstate_t state;
  logic [DATA_W:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dmag;
  logic neg;
  logic zero;
  logic [4:0] cnt;

  logic [DATA_W:0] shifted;
  logic [DATA_W+1:0] diff;
  logic signed [DATA_W:0] qmag;
  logic signed [DATA_W:0] qs;
  logic signed [DATA_W-1:0] qsat;
  logic signed [DATA_W-1:0] qlo;
  logic signed [DATA_W-1:0] qfin;

  // one restoring step
  always_comb begin
    shifted = {rem[DATA_W-1:0], quo[DATA_W-1]};
    diff = {1'b0, shifted} - {2'b00, dmag};
  end

  // sign fix, saturation of the most negative over minus one, then clamp
  always_comb begin
    qmag = $signed({1'b0, quo});
    qs = neg ? -qmag : qmag;
    if (qs > $signed({1'b0, QMAX})) begin
      qsat = QMAX;
    end else begin
      qsat = qs[DATA_W-1:0];
    end
    qlo = (qsat < clamp_min) ? clamp_min : qsat;
    qfin = (qlo > clamp_max) ? clamp_max : qlo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE, D_DONE: begin
          if (start) begin
            rem <= '0;
            quo <= dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
            dmag <= divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);
            neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            zero <= (divisor == '0);
            cnt <= 5'd31;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          if (diff[DATA_W+1]) begin
            rem <= shifted;
            quo <= {quo[DATA_W-2:0], 1'b0};
          end else begin
            rem <= diff[DATA_W:0];
            quo <= {quo[DATA_W-2:0], 1'b1};
          end
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          quotient <= zero ? '0 : qfin;
          zero_divisor <= zero;
          state <= D_DONE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign stat.busy = (state == D_RUN) || (state == D_FIN);
  assign stat.done = (state == D_DONE);

  // a divide-by-zero result is never clamped
  a_zero_q: assert property (@(posedge clk) disable iff (rst)
    (state == D_DONE) && zero_divisor |-> quotient == '0)
    else $error("zero divisor result not zero");
  // the division moves on to its finish once the counter runs out
  a_fin: assert property (@(posedge clk) disable iff (rst)
    (state == D_RUN) && (cnt == 5'd0) |=> state == D_FIN)
    else $error("divider did not finish");
  // the stored remainder stays below the divisor
  a_rem: assert property (@(posedge clk) disable iff (rst)
    (state == D_RUN) && !zero |-> rem < {1'b0, dmag})
    else $error("remainder out of range");

endmodule

@@ hdl/bed_walker.sv @@
// stride derivation, position counter and serial address accumulation
// depends on bed_pkg
module bed_walker #(
  parameter int DIMS = 5,
  parameter int EXTENT_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic rederive,
  input  logic start,
  input  logic [bed_pkg::ADDR_W-1:0] a_extents,
  input  logic [bed_pkg::ADDR_W-1:0] b_extents,
  input  logic [bed_pkg::ADDR_W-1:0] out_extents,
  output bed_pkg::walk_stat_t stat,
  output logic [bed_pkg::ADDR_W-1:0] out_address,
  output logic [bed_pkg::ADDR_W-1:0] next_a_address,
  output logic [bed_pkg::ADDR_W-1:0] next_b_address,
  output logic last
);
  import bed_pkg::*;

  localparam int DIW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int WIDE = DIMS * EXTENT_BITS + ADDR_W;
  localparam logic [DIW-1:0] TOP_DIM = DIW'(DIMS - 1);

  typedef enum logic [2:0] {W_DERIVE, W_IDLE, W_OUT, W_STEP, W_AB, W_DONE} wstate_t;

  wstate_t state;
  logic [DIW-1:0] dim;
  logic [ADDR_W-1:0] ra, rb, ro;
  logic [ADDR_W-1:0] a_str [DIMS];
  logic [ADDR_W-1:0] b_str [DIMS];
  logic [ADDR_W-1:0] o_str [DIMS];
  logic [ADDR_W-1:0] ac [DIMS];
  logic [ADDR_W-1:0] bc [DIMS];
  logic [ADDR_W-1:0] oc [DIMS];
  logic [EXTENT_BITS-1:0] pos [DIMS];

  logic [WIDE-1:0] wa, wb, wo;
  logic [EXTENT_BITS-1:0] ea, eb, eo;
  logic [EXTENT_BITS-1:0] eo_k [DIMS];
  logic [DIMS-1:0] inc, clr;
  logic carry;

  // extents widened so dimensions above the register read as zero
  always_comb begin
    wa = {{(WIDE-ADDR_W){1'b0}}, a_extents};
    wb = {{(WIDE-ADDR_W){1'b0}}, b_extents};
    wo = {{(WIDE-ADDR_W){1'b0}}, out_extents};
    ea = wa[dim*EXTENT_BITS +: EXTENT_BITS];
    eb = wb[dim*EXTENT_BITS +: EXTENT_BITS];
    eo = wo[dim*EXTENT_BITS +: EXTENT_BITS];
    if (eo == '0) begin
      eo = EXTENT_BITS'(1);
    end
    for (int k = 0; k < DIMS; k++) begin
      eo_k[k] = wo[k*EXTENT_BITS +: EXTENT_BITS];
    end
  end

  // carry chain of the row-major step, innermost dimension first
  always_comb begin
    carry = 1'b1;
    inc = '0;
    clr = '0;
    for (int k = DIMS - 1; k >= 0; k--) begin
      if (carry) begin
        if ({1'b0, pos[k]} + 1'b1 >= {1'b0, eo_k[k]}) begin
          clr[k] = 1'b1;
        end else begin
          inc[k] = 1'b1;
          carry = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || rederive) begin
      state <= W_DERIVE;
      dim <= TOP_DIM;
      ra <= ADDR_W'(1);
      rb <= ADDR_W'(1);
      ro <= ADDR_W'(1);
      for (int k = 0; k < DIMS; k++) begin
        pos[k] <= '0;
        ac[k] <= '0;
        bc[k] <= '0;
        oc[k] <= '0;
      end
    end else begin
      case (state)
        // strides from the innermost dimension outward, one per cycle
        W_DERIVE: begin
          a_str[dim] <= (ea == EXTENT_BITS'(1)) ? '0 : ra;
          b_str[dim] <= (eb == EXTENT_BITS'(1)) ? '0 : rb;
          o_str[dim] <= ro;
          ra <= ADDR_W'(ra * ea);
          rb <= ADDR_W'(rb * eb);
          ro <= ADDR_W'(ro * eo);
          if (dim == '0) begin
            state <= W_IDLE;
          end else begin
            dim <= dim - 1'b1;
          end
        end
        W_IDLE, W_DONE: begin
          if (start) begin
            out_address <= '0;
            dim <= '0;
            state <= W_OUT;
          end
        end
        // output address, one dimension a cycle
        W_OUT: begin
          out_address <= out_address + oc[dim];
          if (dim == TOP_DIM) begin
            state <= W_STEP;
          end else begin
            dim <= dim + 1'b1;
          end
        end
        W_STEP: begin
          for (int k = 0; k < DIMS; k++) begin
            if (inc[k]) begin
              pos[k] <= pos[k] + 1'b1;
              ac[k] <= ac[k] + a_str[k];
              bc[k] <= bc[k] + b_str[k];
              oc[k] <= oc[k] + o_str[k];
            end else if (clr[k]) begin
              pos[k] <= '0;
              ac[k] <= '0;
              bc[k] <= '0;
              oc[k] <= '0;
            end
          end
          last <= carry;
          next_a_address <= '0;
          next_b_address <= '0;
          dim <= '0;
          state <= W_AB;
        end
        // operand addresses of the new position
        W_AB: begin
          next_a_address <= next_a_address + ac[dim];
          next_b_address <= next_b_address + bc[dim];
          if (dim == TOP_DIM) begin
            state <= W_DONE;
          end else begin
            dim <= dim + 1'b1;
          end
        end
        default: state <= W_DERIVE;
      endcase
    end
  end

  assign stat.ready = (state == W_IDLE) || (state == W_DONE);
  assign stat.done = (state == W_DONE);

  // a start only takes effect when the walker is idle or done
  a_start: assert property (@(posedge clk) disable iff (rst || rederive)
    start && stat.ready |=> state == W_OUT)
    else $error("walker missed a start");
  // the operand address sum always follows the step
  a_step: assert property (@(posedge clk) disable iff (rst || rederive)
    state == W_STEP |=> state == W_AB)
    else $error("walker step out of order");
  // at most one dimension counts up per step
  a_inc: assert property (@(posedge clk) disable iff (rst)
    $onehot0(inc))
    else $error("more than one dimension incremented");

endmodule

@@ hdl/broadcast_elementwise_divide.sv @@
// top level: configuration registers, item control, divider and walker
// depends on bed_pkg, bed_if, bed_divider, bed_walker
//
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid / ready    | dividend, divisor
//  out_ch   | out | valid / ready    | out_address, quotient, zero_divisor, next addrs, last
//  apb      | in  | psel / penable   | paddr, pwdata, prdata (8 byte register spacing)
//
// a result is loaded once the divider and the walker are done and the output register
// is free: the operands load at the transfer, then come 32 divider iterations, one
// finish and one output load. the next transfer can be taken in the cycle after the
// output load, so a new item is never taken before the last one's result is loaded.
// after reset and after any extent write the strides are derived again,
// with in_ch.ready low meanwhile. reset is synchronous and active high.
// a result waits in the output register while out_ch.ready is low; the next item
// is taken meanwhile but its result waits for the register to empty.
module broadcast_elementwise_divide #(
  parameter int DIMS = 5,
  parameter int EXTENT_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  bed_in_if.sink in_ch,
  bed_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [bed_pkg::APB_AW-1:0] paddr,
  input  logic [bed_pkg::APB_DW-1:0] pwdata,
  output logic [bed_pkg::APB_DW-1:0] prdata,
  output logic pready
);
  import bed_pkg::*;

  typedef enum logic [2:0] {
    REG_A_EXT, REG_B_EXT, REG_OUT_EXT, REG_CLAMP_MIN, REG_CLAMP_MAX
  } reg_idx_t;

  typedef enum logic {S_IDLE, S_RUN} tstate_t;

  tstate_t state;
  logic [ADDR_W-1:0] a_extents, b_extents, out_extents;
  logic signed [DATA_W-1:0] clamp_min, clamp_max;
  logic [2:0] ridx;
  logic wr;
  logic rederive;
  logic accept;
  logic load;
  walk_stat_t wstat;
  div_stat_t dstat;
  logic [ADDR_W-1:0] w_out, w_na, w_nb;
  logic w_last;
  logic signed [DATA_W-1:0] d_q;
  logic d_zero;

  // configuration port
  assign pready = 1'b1;
  assign ridx = paddr[5:3];
  assign wr = psel && penable && pwrite && pready;
  assign rederive = wr && ((ridx == REG_A_EXT) || (ridx == REG_B_EXT) ||
                           (ridx == REG_OUT_EXT));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_extents <= EXT_RESET;
      b_extents <= EXT_RESET;
      out_extents <= EXT_RESET;
      clamp_min <= QMIN;
      clamp_max <= QMAX;
    end else if (wr) begin
      case (ridx)
        REG_A_EXT: a_extents <= pwdata[ADDR_W-1:0];
        REG_B_EXT: b_extents <= pwdata[ADDR_W-1:0];
        REG_OUT_EXT: out_extents <= pwdata[ADDR_W-1:0];
        REG_CLAMP_MIN: clamp_min <= pwdata[DATA_W-1:0];
        REG_CLAMP_MAX: clamp_max <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (ridx)
      REG_A_EXT: prdata = APB_DW'(a_extents);
      REG_B_EXT: prdata = APB_DW'(b_extents);
      REG_OUT_EXT: prdata = APB_DW'(out_extents);
      REG_CLAMP_MIN: prdata = APB_DW'(unsigned'(clamp_min));
      REG_CLAMP_MAX: prdata = APB_DW'(unsigned'(clamp_max));
      default: prdata = '0;
    endcase
  end

  // item control and output register
  assign in_ch.ready = (state == S_IDLE) && wstat.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign load = (state == S_RUN) && dstat.done && wstat.done &&
                (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      if (load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (load) begin
            out_ch.out_address <= w_out;
            out_ch.quotient <= d_q;
            out_ch.zero_divisor <= d_zero;
            out_ch.next_a_address <= w_na;
            out_ch.next_b_address <= w_nb;
            out_ch.last <= w_last;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bed_divider u_div (
    .clk(clk),
    .rst(rst),
    .start(accept),
    .dividend(in_ch.dividend),
    .divisor(in_ch.divisor),
    .clamp_min(clamp_min),
    .clamp_max(clamp_max),
    .stat(dstat),
    .quotient(d_q),
    .zero_divisor(d_zero)
  );

  bed_walker #(
    .DIMS(DIMS),
    .EXTENT_BITS(EXTENT_BITS)
  ) u_walk (
    .clk(clk),
    .rst(rst),
    .rederive(rederive),
    .start(accept),
    .a_extents(a_extents),
    .b_extents(b_extents),
    .out_extents(out_extents),
    .stat(wstat),
    .out_address(w_out),
    .next_a_address(w_na),
    .next_b_address(w_nb),
    .last(w_last)
  );

  // one item in flight at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ch.ready)
    else $error("second item accepted while busy");
  // the divider is busy in the cycle after a transfer
  a_div_go: assert property (@(posedge clk) disable iff (rst)
    accept |=> dstat.busy)
    else $error("divider not started");
  // a result is only loaded once both units are done
  a_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) && !(dstat.done && wstat.done) |=> state == S_RUN)
    else $error("result loaded early");

endmodule
